@@ rtl/gbfs_pkg.sv @@
// Shared types and constants for the grid bucket feature select block.
// Used by the RAM-facing datapath, the divider, the controller and the top level.
package gbfs_pkg;

  localparam int COORD_W    = 12;
  localparam int LEVEL_W    = 3;
  localparam int SCORE_W    = 32;
  localparam int DIM_W      = 13;
  localparam int GRID_W     = 7;
  localparam int GIDX_W     = 6;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int FUNC_W     = 2;

  // divider operands: coordinate times grid dimension over image size
  localparam int DVD_W = COORD_W + GRID_W;
  localparam int DVS_W = DIM_W;

  localparam logic [GRID_W-1:0] GRID_MAX = 7'd64;

  localparam logic [DIM_W-1:0]   RST_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0]   RST_HEIGHT  = 13'd480;
  localparam logic [GRID_W-1:0]  RST_COLS    = 7'd25;
  localparam logic [GRID_W-1:0]  RST_ROWS    = 7'd25;
  localparam logic [SCORE_W-1:0] RST_THRESH  = 32'd20480;
  localparam logic [CNT_W-1:0]   RST_MAXFEAT = 13'd1000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_BLOCK = 2'd1,
    FUNC_CAND  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_COLS    = 3'd2,
    CFG_ROWS    = 3'd3,
    CFG_THRESH  = 3'd4,
    CFG_MAXFEAT = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_ROW_GO,
    ST_ROW_WAIT,
    ST_CELL,
    ST_MEM_RD,
    ST_UPDATE,
    ST_READ,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 blocked;
    logic [SCORE_W-1:0]   score;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [LEVEL_W-1:0]   lvl;
  } cell_t;

  typedef struct packed {
    logic load;
    logic frame_clear;
    logic clr_wr;
    logic div_col;
    logic div_row;
    logic col_latch;
    logic row_latch;
    logic cell_latch;
    logic mem_rd;
    logic mem_upd;
    logic scan_rd;
    logic res_done;
    logic res_found;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic k_out;
    logic at_limit;
    logic scan_end;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/gbfs_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/gbfs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cell index mapping.
// Depends on gbfs_pkg for operand widths.
module gbfs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gbfs_pkg::DVD_W-1:0]   dividend,
  input  logic [gbfs_pkg::DVS_W-1:0]   divisor,
  output logic [gbfs_pkg::DVD_W-1:0]   quotient,
  output logic                         done
);

  localparam int STEP_W = $clog2(gbfs_pkg::DVD_W);

  logic [gbfs_pkg::DVS_W-1:0] rem;
  logic [gbfs_pkg::DVS_W-1:0] dvs;
  logic [gbfs_pkg::DVD_W-1:0] quo;
  logic [STEP_W-1:0]          step;
  logic                       busy;
  logic [gbfs_pkg::DVS_W:0]   trial;
  logic                       take;

  assign trial    = {rem, quo[gbfs_pkg::DVD_W-1]};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(gbfs_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? gbfs_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[gbfs_pkg::DVS_W-1:0];
      quo <= {quo[gbfs_pkg::DVD_W-2:0], take};
    end
  end

endmodule

@@ rtl/gbfs_ctrl.sv @@
// Controller state machine: sequences clear sweeps, cell mapping,
// cell updates and scans. Depends on gbfs_pkg for state, command and status types.
module gbfs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [gbfs_pkg::FUNC_W-1:0]  in_func,
  input  gbfs_pkg::stat_t              stat,
  output logic                         in_ready,
  output gbfs_pkg::cmd_t               cmd
);

  gbfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbfs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gbfs_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = gbfs_pkg::ST_IDLE;
      end
      gbfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (gbfs_pkg::func_t'(in_func))
            gbfs_pkg::FUNC_START: state_next = gbfs_pkg::ST_CLEAR;
            gbfs_pkg::FUNC_BLOCK: state_next = gbfs_pkg::ST_COL_GO;
            gbfs_pkg::FUNC_CAND:  state_next = gbfs_pkg::ST_COL_GO;
            gbfs_pkg::FUNC_READ:  state_next = gbfs_pkg::ST_READ;
            default:              state_next = gbfs_pkg::ST_IDLE;
          endcase
        end
      end
      gbfs_pkg::ST_COL_GO:   state_next = gbfs_pkg::ST_COL_WAIT;
      gbfs_pkg::ST_COL_WAIT: begin
        if (stat.div_done) state_next = gbfs_pkg::ST_ROW_GO;
      end
      gbfs_pkg::ST_ROW_GO:   state_next = gbfs_pkg::ST_ROW_WAIT;
      gbfs_pkg::ST_ROW_WAIT: begin
        if (stat.div_done) state_next = gbfs_pkg::ST_CELL;
      end
      gbfs_pkg::ST_CELL:     state_next = gbfs_pkg::ST_MEM_RD;
      gbfs_pkg::ST_MEM_RD: begin
        state_next = stat.k_out ? gbfs_pkg::ST_IDLE : gbfs_pkg::ST_UPDATE;
      end
      gbfs_pkg::ST_UPDATE:   state_next = gbfs_pkg::ST_IDLE;
      gbfs_pkg::ST_READ: begin
        state_next = stat.at_limit ? gbfs_pkg::ST_EMIT : gbfs_pkg::ST_SCAN_RD;
      end
      gbfs_pkg::ST_SCAN_RD: begin
        state_next = stat.scan_end ? gbfs_pkg::ST_EMIT : gbfs_pkg::ST_SCAN_CHK;
      end
      gbfs_pkg::ST_SCAN_CHK: begin
        state_next = stat.hit ? gbfs_pkg::ST_EMIT : gbfs_pkg::ST_SCAN_RD;
      end
      gbfs_pkg::ST_EMIT: begin
        if (stat.out_free) state_next = gbfs_pkg::ST_IDLE;
      end
      default: state_next = gbfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      gbfs_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      gbfs_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load        = in_valid;
        cmd.frame_clear = in_valid && (in_func == gbfs_pkg::FUNC_START);
      end
      gbfs_pkg::ST_COL_GO:   cmd.div_col    = 1'b1;
      gbfs_pkg::ST_COL_WAIT: cmd.col_latch  = stat.div_done;
      gbfs_pkg::ST_ROW_GO:   cmd.div_row    = 1'b1;
      gbfs_pkg::ST_ROW_WAIT: cmd.row_latch  = stat.div_done;
      gbfs_pkg::ST_CELL:     cmd.cell_latch = 1'b1;
      gbfs_pkg::ST_MEM_RD:   cmd.mem_rd     = !stat.k_out;
      gbfs_pkg::ST_UPDATE:   cmd.mem_upd    = 1'b1;
      gbfs_pkg::ST_READ:     cmd.res_done   = stat.at_limit;
      gbfs_pkg::ST_SCAN_RD: begin
        cmd.res_done = stat.scan_end;
        cmd.scan_rd  = !stat.scan_end;
      end
      gbfs_pkg::ST_SCAN_CHK: cmd.res_found  = stat.hit;
      gbfs_pkg::ST_EMIT:     cmd.push       = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/gbfs_dp.sv @@
// Datapath: configuration registers, cell store, shared divider, scan
// pointers and output register. Depends on gbfs_pkg, gbfs_ram and gbfs_div.
module gbfs_dp #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [gbfs_pkg::FUNC_W-1:0]       in_func,
  input  logic [gbfs_pkg::COORD_W-1:0]      in_x,
  input  logic [gbfs_pkg::COORD_W-1:0]      in_y,
  input  logic [gbfs_pkg::LEVEL_W-1:0]      in_lvl,
  input  logic [gbfs_pkg::SCORE_W-1:0]      in_score,
  input  gbfs_pkg::cmd_t                    cmd,
  output gbfs_pkg::stat_t                   stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [gbfs_pkg::COORD_W-1:0]      out_x,
  output logic [gbfs_pkg::COORD_W-1:0]      out_y,
  output logic [gbfs_pkg::LEVEL_W-1:0]      out_lvl,
  output logic                              out_done
);

  localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W = gbfs_pkg::CNT_W;

  // configuration
  logic [gbfs_pkg::DIM_W-1:0]   img_w, img_h;
  logic [gbfs_pkg::GRID_W-1:0]  grid_cols, grid_rows;
  logic [gbfs_pkg::SCORE_W-1:0] thresh;
  logic [CNT_W-1:0]             max_feat;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w     <= gbfs_pkg::RST_WIDTH;
      img_h     <= gbfs_pkg::RST_HEIGHT;
      grid_cols <= gbfs_pkg::RST_COLS;
      grid_rows <= gbfs_pkg::RST_ROWS;
      thresh    <= gbfs_pkg::RST_THRESH;
      max_feat  <= gbfs_pkg::RST_MAXFEAT;
    end else if (cfg_wen) begin
      case (cfg_index)
        gbfs_pkg::CFG_WIDTH:   img_w     <= cfg_data[gbfs_pkg::DIM_W-1:0];
        gbfs_pkg::CFG_HEIGHT:  img_h     <= cfg_data[gbfs_pkg::DIM_W-1:0];
        gbfs_pkg::CFG_COLS:    grid_cols <= cfg_data[gbfs_pkg::GRID_W-1:0];
        gbfs_pkg::CFG_ROWS:    grid_rows <= cfg_data[gbfs_pkg::GRID_W-1:0];
        gbfs_pkg::CFG_THRESH:  thresh    <= cfg_data[gbfs_pkg::SCORE_W-1:0];
        gbfs_pkg::CFG_MAXFEAT: max_feat  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero counts as one, grid clamps at 64
  logic [gbfs_pkg::DIM_W-1:0]  eff_w, eff_h;
  logic [gbfs_pkg::GRID_W-1:0] eff_cols, eff_rows;
  logic [CNT_W:0]              grid_prod;
  logic [CNT_W-1:0]            n_cells;

  assign eff_w    = (img_w == '0) ? gbfs_pkg::DIM_W'(1) : img_w;
  assign eff_h    = (img_h == '0) ? gbfs_pkg::DIM_W'(1) : img_h;
  assign eff_cols = (grid_cols == '0) ? gbfs_pkg::GRID_W'(1) :
                    (grid_cols > gbfs_pkg::GRID_MAX) ? gbfs_pkg::GRID_MAX : grid_cols;
  assign eff_rows = (grid_rows == '0) ? gbfs_pkg::GRID_W'(1) :
                    (grid_rows > gbfs_pkg::GRID_MAX) ? gbfs_pkg::GRID_MAX : grid_rows;
  assign grid_prod = (CNT_W + 1)'(eff_rows) * (CNT_W + 1)'(eff_cols);
  assign n_cells   = (grid_prod > (CNT_W + 1)'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                           : grid_prod[CNT_W-1:0];

  // latched input item
  logic                         item_block;
  logic [gbfs_pkg::COORD_W-1:0] item_x, item_y;
  logic [gbfs_pkg::LEVEL_W-1:0] item_lvl;
  logic [gbfs_pkg::SCORE_W-1:0] item_score;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_block <= (in_func == gbfs_pkg::FUNC_BLOCK);
      item_x     <= in_x;
      item_y     <= in_y;
      item_lvl   <= in_lvl;
      item_score <= in_score;
    end
  end

  // shared divider for column and row
  logic [gbfs_pkg::DVD_W-1:0] div_dvd, div_quo;
  logic [gbfs_pkg::DVS_W-1:0] div_dvs;
  logic                       div_done;

  assign div_dvd = cmd.div_row
                 ? gbfs_pkg::DVD_W'(item_y) * gbfs_pkg::DVD_W'(eff_rows)
                 : gbfs_pkg::DVD_W'(item_x) * gbfs_pkg::DVD_W'(eff_cols);
  assign div_dvs = cmd.div_row ? eff_h : eff_w;

  gbfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_col | cmd.div_row),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  logic [gbfs_pkg::GIDX_W-1:0] col, row;
  logic [CNT_W-1:0]            cell_k, cell_k_next;

  assign cell_k_next = CNT_W'(row) * CNT_W'(eff_cols) + CNT_W'(col);

  always_ff @(posedge clk) begin
    if (cmd.col_latch) begin
      col <= (div_quo >= gbfs_pkg::DVD_W'(eff_cols))
           ? gbfs_pkg::GIDX_W'(eff_cols - 1'b1) : div_quo[gbfs_pkg::GIDX_W-1:0];
    end
    if (cmd.row_latch) begin
      row <= (div_quo >= gbfs_pkg::DVD_W'(eff_rows))
           ? gbfs_pkg::GIDX_W'(eff_rows - 1'b1) : div_quo[gbfs_pkg::GIDX_W-1:0];
    end
    if (cmd.cell_latch) begin
      cell_k <= cell_k_next;
    end
  end

  // frame pointers and clear sweep address
  logic [AW-1:0]    clr_addr;
  logic [CNT_W-1:0] scan_index, emitted;

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      clr_addr   <= '0;
      scan_index <= '0;
      emitted    <= '0;
    end else begin
      if (cmd.clr_wr)    clr_addr   <= clr_addr + 1'b1;
      if (cmd.scan_rd)   scan_index <= scan_index + 1'b1;
      if (cmd.res_found) emitted    <= emitted + 1'b1;
    end
  end

  // cell store
  gbfs_pkg::cell_t                    rd_entry, new_entry;
  logic [$bits(gbfs_pkg::cell_t)-1:0] rd_data;
  logic                               upd_wr;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr, rd_addr;

  assign rd_entry = gbfs_pkg::cell_t'(rd_data);

  always_comb begin
    new_entry.blocked = item_block;
    new_entry.score   = item_block ? '0 : item_score;
    new_entry.x       = item_x;
    new_entry.y       = item_y;
    new_entry.lvl     = item_lvl;
  end

  assign upd_wr  = cmd.mem_upd &&
                   (item_block || (!rd_entry.blocked && (item_score > rd_entry.score)));
  assign wr_en   = cmd.clr_wr || upd_wr;
  assign wr_addr = cmd.clr_wr ? clr_addr : cell_k[AW-1:0];
  assign rd_addr = cmd.scan_rd ? scan_index[AW-1:0] : cell_k[AW-1:0];

  gbfs_ram #(
    .WIDTH ($bits(gbfs_pkg::cell_t)),
    .DEPTH (MAX_CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.clr_wr ? '0 : new_entry),
    .rd_en   (cmd.mem_rd || cmd.scan_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // pending result and output register
  logic                         pend_found, pend_done;
  logic [gbfs_pkg::COORD_W-1:0] pend_x, pend_y;
  logic [gbfs_pkg::LEVEL_W-1:0] pend_lvl;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.res_done) begin
      pend_found <= 1'b0;
      pend_done  <= 1'b1;
      pend_x     <= '0;
      pend_y     <= '0;
      pend_lvl   <= '0;
    end else if (cmd.res_found) begin
      pend_found <= 1'b1;
      pend_done  <= 1'b0;
      pend_x     <= rd_entry.x;
      pend_y     <= rd_entry.y;
      pend_lvl   <= rd_entry.lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found <= pend_found;
      out_done  <= pend_done;
      out_x     <= pend_x;
      out_y     <= pend_y;
      out_lvl   <= pend_lvl;
    end
  end

  assign stat.clr_last = (clr_addr == AW'(MAX_CELLS - 1));
  assign stat.div_done = div_done;
  assign stat.k_out    = (cell_k >= CNT_W'(MAX_CELLS));
  assign stat.at_limit = (emitted >= max_feat);
  assign stat.scan_end = (scan_index >= n_cells);
  assign stat.hit      = (rd_entry.score > thresh);
  assign stat.out_free = out_free;

  a_found_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_found && out_done))
    else $error("result marked both found and done");

  a_emit_le_scan: assert property (@(posedge clk) disable iff (rst)
    emitted <= scan_index)
    else $error("more features emitted than cells scanned");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> out_free)
    else $error("result pushed over an untaken result");

  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !(cmd.mem_upd || cmd.scan_rd || cmd.mem_rd))
    else $error("cell store accessed during clear sweep");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_index <= CNT_W'(MAX_CELLS))
    else $error("scan pointer ran past the cell store");

endmodule

@@ rtl/grid_bucket_feature_select.sv @@
// Top level of the grid bucket feature select block.
// Depends on gbfs_pkg, gbfs_ctrl and gbfs_dp (which holds gbfs_div and gbfs_ram).
//
// Usage:
//   s_axis carries one command per transfer: tuser is the function (start
//   frame, block existing corner, candidate, read next), tdata the position,
//   level and score. Start clears every cell, block marks the cell of a
//   position as taken, candidate keeps the best score per cell, read returns
//   the next cell in index order whose score exceeds the threshold.
//   m_axis carries one transfer per read only: tuser high when a feature is
//   returned, tlast high when the scan is finished or the feature limit hit.
//   cfg_wen/cfg_index/cfg_data write the six settings; write them only idle.
// Sequence:
//   Block and candidate items run two 19-step divisions on the shared divider,
//   then cell index, store read and store write, before the next accept.
//   A read checks the feature limit, then does one store read and one
//   threshold check per cell visited, and a last end check when it runs
//   off the end of the scan.
//   A start item runs a clear sweep over all MAX_CELLS cells; after reset the same
//   sweep runs before s_axis_tready first rises.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   block keeps taking non-read items meanwhile and holds the next read result
//   until the register frees.
module grid_bucket_feature_select #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // command stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gbfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // pos_x, pos_y, level, score, zeros
  input  logic [gbfs_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gbfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // feature_x, feature_y, feature_level, zeros
  output logic                              m_axis_tuser,  // found
  output logic                              m_axis_tlast   // done_res
);

  localparam int CW = gbfs_pkg::COORD_W;
  localparam int LW = gbfs_pkg::LEVEL_W;
  localparam int SW = gbfs_pkg::SCORE_W;
  localparam int OUT_PAD = gbfs_pkg::OUT_DATA_W - 2 * CW - LW;

  gbfs_pkg::cmd_t  cmd;
  gbfs_pkg::stat_t stat;

  logic [CW-1:0] in_x, in_y, out_x, out_y;
  logic [LW-1:0] in_lvl, out_lvl;
  logic [SW-1:0] in_score;

  // unpack the command fields, lowest field first
  assign in_x     = s_axis_tdata[CW-1:0];
  assign in_y     = s_axis_tdata[2*CW-1:CW];
  assign in_lvl   = s_axis_tdata[2*CW+LW-1:2*CW];
  assign in_score = s_axis_tdata[2*CW+LW+SW-1:2*CW+LW];

  gbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  gbfs_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_func   (s_axis_tuser),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_lvl    (in_lvl),
    .in_score  (in_score),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_found (m_axis_tuser),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_lvl   (out_lvl),
    .out_done  (m_axis_tlast)
  );

  // pack the result fields, lowest field first, zero fill to a whole word
  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_lvl, out_y, out_x};

endmodule
